/* hdl/alarm_clock_set_controller_assert.svh */
// Assertion macros shared by the alarm clock set controller RTL.
`ifndef ALARM_CLOCK_SET_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_SET_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define ACSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Assertion failed in alarm clock set controller.");

// Next-cycle implication, checked on clk and disabled during reset.
`define ACSC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Assertion failed in alarm clock set controller.");

`endif

/* hdl/acsc_pkg.sv */
// Package with constants and helper functions of the alarm clock set controller.
`default_nettype none

package acsc_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PERIOD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_PERIOD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_PERIOD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_LIMIT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_COUNT = 3'd5;

	localparam logic [15:0] UPDATE_PERIOD_RST = 16'd1100;
	localparam logic [15:0] KEY_PERIOD_RST = 16'd600;
	localparam logic [15:0] FLASH_PERIOD_RST = 16'd2000;
	localparam logic [15:0] BLINK_PERIOD_RST = 16'd10000;
	localparam logic [15:0] WRAP_LIMIT_RST = 16'd50000;
	localparam logic [5:0] FLASH_COUNT_RST = 6'd25;

	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_SET_TIME = 3'd1;
	localparam logic [2:0] KEY_SET_ALARM = 3'd2;
	localparam logic [2:0] KEY_UP = 3'd3;
	localparam logic [2:0] KEY_DOWN = 3'd4;

	localparam logic [3:0] DIGIT_BLANK = 4'd12;
	localparam logic [5:0] HOUR_MAX = 6'd23;
	localparam logic [5:0] MIN_SEC_MAX = 6'd59;

	localparam logic [4:0] RUN_HOUR_RST = 5'd23;
	localparam logic [5:0] RUN_MINUTE_RST = 6'd59;
	localparam logic [5:0] RUN_SECOND_RST = 6'd50;
	localparam logic [3:0] DIGIT_RST [6] = '{4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'd0};

	// A period of zero counts as 65536.
	function automatic logic [16:0] period_ext(input logic [15:0] p);
		return {(p == 16'd0), p};
	endfunction

	// Residue of the tick count after one increment, or zero when wrap is set.
	function automatic logic [15:0] res_step(input logic [15:0] r, input logic [15:0] p,
		input logic wrap);
		logic [16:0] r_inc;
		r_inc = {1'b0, r} + 17'd1;
		if (wrap || (r_inc == period_ext(p))) begin
			return 16'd0;
		end
		return r_inc[15:0];
	endfunction

	function automatic logic [5:0] bcd_to_bin(input logic [6:0] bcd, input logic [5:0] limit);
		logic [6:0] t;
		logic [6:0] x;
		t = {4'd0, bcd[6:4]};
		x = (t << 3) + (t << 1) + {3'd0, bcd[3:0]};
		if (x > {1'b0, limit}) begin
			return limit;
		end
		return x[5:0];
	endfunction

	function automatic logic [3:0] tens_of(input logic [5:0] v);
		if (v >= 6'd50) begin
			return 4'd5;
		end else if (v >= 6'd40) begin
			return 4'd4;
		end else if (v >= 6'd30) begin
			return 4'd3;
		end else if (v >= 6'd20) begin
			return 4'd2;
		end else if (v >= 6'd10) begin
			return 4'd1;
		end
		return 4'd0;
	endfunction

	function automatic logic [3:0] ones_of(input logic [5:0] v);
		logic [5:0] t;
		logic [5:0] d;
		t = {2'd0, tens_of(v)};
		d = v - ((t << 3) + (t << 1));
		return d[3:0];
	endfunction

	function automatic logic [6:0] to_bcd(input logic [5:0] v);
		logic [3:0] t;
		t = tens_of(v);
		return {t[2:0], ones_of(v)};
	endfunction

	// Saturating step of one time field.
	function automatic logic [5:0] bump(input logic [5:0] v, input logic [5:0] limit,
		input logic up, input logic en);
		if (!en) begin
			return v;
		end
		if (up) begin
			return (v < limit) ? v + 6'd1 : v;
		end
		return (v > 6'd0) ? v - 6'd1 : v;
	endfunction

endpackage

`default_nettype wire

/* hdl/alarm_clock_set_controller.sv */
// Alarm clock set controller: tick-paced time display, time setting and alarm.
//
// Each input transaction is one 100 us tick carrying the debounced key code and
// the real-time clock time in BCD. Every accepted tick gives exactly one output
// transaction with six display digits (12 is blank), the LED latch bit and an
// optional clock write (write_strobe with the BCD time to write).
// The tick is captured in an input register; the next-state logic runs in one
// pass from there into the output register, which drives out_valid; one tick
// can be accepted every cycle while no stall or resynchronization holds it off.
// When the receiver stalls, the output register holds its transaction, one
// more tick waits in the input register, and in_ready drops after that.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once.
// Each write starts a resynchronization of the four period phase counters
// against the tick count: a bit-serial remainder unit takes each period in turn,
// and in_ready is low throughout.
// Reset restores the default periods, the time 23:59:50, alarm 00:00:00,
// the idle state and an empty pipeline; no resynchronization is needed then.
`default_nettype none
`include "alarm_clock_set_controller_assert.svh"

module alarm_clock_set_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [acsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [acsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          key_code,
	input  logic [5:0]                          clock_hour_bcd,
	input  logic [6:0]                          clock_minute_bcd,
	input  logic [6:0]                          clock_second_bcd,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [3:0]                          hour_tens,
	output logic [3:0]                          hour_ones,
	output logic [3:0]                          minute_tens,
	output logic [3:0]                          minute_ones,
	output logic [3:0]                          second_tens,
	output logic [3:0]                          second_ones,
	output logic                                led_level,
	output logic                                write_strobe,
	output logic [5:0]                          write_hour_bcd,
	output logic [6:0]                          write_minute_bcd,
	output logic [6:0]                          write_second_bcd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HOUR,
		ST_MINUTE,
		ST_SECOND,
		ST_RING
	} main_state_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_RUNTIME,
		MODE_ALARM
	} set_mode_t;

	logic [15:0] update_period_q, key_period_q, flash_period_q, blink_period_q;
	logic [15:0] wrap_limit_q;
	logic [5:0]  flash_count_q;

	logic [15:0] tick_q;
	logic [15:0] res_upd_q, res_key_q, res_flash_q, res_blink_q;
	logic [4:0]  run_hour_q, alarm_hour_q;
	logic [5:0]  run_minute_q, run_second_q, alarm_minute_q, alarm_second_q;
	set_mode_t   set_mode_q;
	main_state_t main_state_q;
	logic        blink_q, flash_flag_q, led_q;
	logic [5:0]  flash_cnt_q;
	logic [3:0]  dig_q [6];

	logic        resync_q;
	logic [1:0]  rs_sel_q;
	logic [3:0]  rs_bit_q;
	logic [15:0] rs_rem_q;

	logic        valid_s1;
	logic [2:0]  key_s1;
	logic [5:0]  hour_s1;
	logic [6:0]  minute_s1, second_s1;

	logic        advance;
	logic [15:0] tick_inc, tick_n;
	logic        tick_top, clr;
	logic [15:0] rb1, rf1, ru1, rk1;
	logic [15:0] rb2, rf2, ru2, rk2;
	logic        blink_hit, flash_hit, upd_hit, key_hit;

	main_state_t ms;
	set_mode_t   sm;
	logic        blink_n, ff_n, led_n, wr_n, up_n, rt_n, al_n;
	logic [5:0]  fc_n, fc_inc;
	logic [5:0]  rh, rm, rs, ah, am, as_n;
	logic [5:0]  sel_h, sel_m, sel_s;
	logic [3:0]  dig_n [6];

	logic [15:0] rs_period;
	logic [16:0] rs_div, rs_sh, rs_rem_n;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !resync_q && (!valid_s1 || advance);

	always_comb begin
		tick_inc  = tick_q + 16'd1;
		tick_top  = (tick_q == 16'hFFFF);
		rb1       = acsc_pkg::res_step(res_blink_q, blink_period_q, tick_top);
		rf1       = acsc_pkg::res_step(res_flash_q, flash_period_q, tick_top);
		ru1       = acsc_pkg::res_step(res_upd_q, update_period_q, tick_top);
		rk1       = acsc_pkg::res_step(res_key_q, key_period_q, tick_top);
		clr       = (tick_inc > wrap_limit_q);
		tick_n    = clr ? 16'd0 : tick_inc;
		rb2       = clr ? 16'd0 : rb1;
		rf2       = clr ? 16'd0 : rf1;
		ru2       = clr ? 16'd0 : ru1;
		rk2       = clr ? 16'd0 : rk1;
		blink_hit = (rb1 == 16'd0);
		flash_hit = (rf1 == 16'd0);
		upd_hit   = (ru2 == 16'd0);
		key_hit   = (rk2 == 16'd0);
	end

	always_comb begin
		ms      = main_state_q;
		sm      = set_mode_q;
		blink_n = blink_q ^ blink_hit;
		ff_n    = flash_flag_q;
		led_n   = led_q;
		fc_n    = flash_cnt_q;
		fc_inc  = flash_cnt_q + 6'd1;
		rh      = {1'b0, run_hour_q};
		rm      = run_minute_q;
		rs      = run_second_q;
		ah      = {1'b0, alarm_hour_q};
		am      = alarm_minute_q;
		as_n    = alarm_second_q;
		wr_n    = 1'b0;
		up_n    = (key_s1 == acsc_pkg::KEY_UP);
		rt_n    = 1'b0;
		al_n    = 1'b0;
		sel_h   = rh;
		sel_m   = rm;
		sel_s   = rs;
		for (int i = 0; i < 6; i++) begin
			dig_n[i] = dig_q[i];
		end

		if (ms == ST_RING && flash_hit) begin
			led_n = flash_flag_q;
			ff_n  = !flash_flag_q;
			fc_n  = fc_inc;
			if (fc_inc >= flash_count_q) begin
				led_n = 1'b1;
				ms    = ST_IDLE;
				fc_n  = 6'd0;
			end
		end

		if (upd_hit) begin
			if (ms == ST_IDLE) begin
				rh       = acsc_pkg::bcd_to_bin({1'b0, hour_s1}, acsc_pkg::HOUR_MAX);
				rm       = acsc_pkg::bcd_to_bin(minute_s1, acsc_pkg::MIN_SEC_MAX);
				rs       = acsc_pkg::bcd_to_bin(second_s1, acsc_pkg::MIN_SEC_MAX);
				dig_n[0] = acsc_pkg::tens_of(rh);
				dig_n[1] = acsc_pkg::ones_of(rh);
				dig_n[2] = acsc_pkg::tens_of(rm);
				dig_n[3] = acsc_pkg::ones_of(rm);
				dig_n[4] = acsc_pkg::tens_of(rs);
				dig_n[5] = acsc_pkg::ones_of(rs);
			end
			if (sm == MODE_RUNTIME || sm == MODE_ALARM) begin
				sel_h    = (sm == MODE_RUNTIME) ? rh : ah;
				sel_m    = (sm == MODE_RUNTIME) ? rm : am;
				sel_s    = (sm == MODE_RUNTIME) ? rs : as_n;
				dig_n[0] = (blink_n && ms == ST_HOUR) ? acsc_pkg::DIGIT_BLANK
					: acsc_pkg::tens_of(sel_h);
				dig_n[1] = (blink_n && ms == ST_HOUR) ? acsc_pkg::DIGIT_BLANK
					: acsc_pkg::ones_of(sel_h);
				dig_n[2] = (blink_n && ms == ST_MINUTE) ? acsc_pkg::DIGIT_BLANK
					: acsc_pkg::tens_of(sel_m);
				dig_n[3] = (blink_n && ms == ST_MINUTE) ? acsc_pkg::DIGIT_BLANK
					: acsc_pkg::ones_of(sel_m);
				dig_n[4] = (blink_n && ms == ST_SECOND) ? acsc_pkg::DIGIT_BLANK
					: acsc_pkg::tens_of(sel_s);
				dig_n[5] = (blink_n && ms == ST_SECOND) ? acsc_pkg::DIGIT_BLANK
					: acsc_pkg::ones_of(sel_s);
			end
			if (rh == ah && rm == am && rs == as_n && ms != ST_RING) begin
				ms   = ST_RING;
				fc_n = 6'd0;
			end
		end

		if (key_hit && key_s1 >= acsc_pkg::KEY_SET_TIME && key_s1 <= acsc_pkg::KEY_DOWN) begin
			if (key_s1 == acsc_pkg::KEY_SET_TIME || key_s1 == acsc_pkg::KEY_SET_ALARM) begin
				if (ms == ST_IDLE) begin
					sm = set_mode_t'(key_s1[1:0]);
				end
				if (sm == set_mode_t'(key_s1[1:0])) begin
					case (ms)
						ST_IDLE: begin
							ms = ST_HOUR;
						end
						ST_HOUR: begin
							ms = ST_MINUTE;
						end
						ST_MINUTE: begin
							ms = ST_SECOND;
						end
						ST_SECOND: begin
							wr_n = (sm == MODE_RUNTIME);
							ms   = ST_IDLE;
							sm   = MODE_NONE;
						end
						default: begin
							ms = ST_IDLE;
						end
					endcase
				end
			end else begin
				rt_n = (sm == MODE_RUNTIME);
				al_n = (sm == MODE_ALARM);
				case (ms)
					ST_HOUR: begin
						rh = acsc_pkg::bump(rh, acsc_pkg::HOUR_MAX, up_n, rt_n);
						ah = acsc_pkg::bump(ah, acsc_pkg::HOUR_MAX, up_n, al_n);
					end
					ST_MINUTE: begin
						rm = acsc_pkg::bump(rm, acsc_pkg::MIN_SEC_MAX, up_n, rt_n);
						am = acsc_pkg::bump(am, acsc_pkg::MIN_SEC_MAX, up_n, al_n);
					end
					ST_SECOND: begin
						rs   = acsc_pkg::bump(rs, acsc_pkg::MIN_SEC_MAX, up_n, rt_n);
						as_n = acsc_pkg::bump(as_n, acsc_pkg::MIN_SEC_MAX, up_n, al_n);
					end
					default: begin
					end
				endcase
			end
			if (ms == ST_RING) begin
				ms    = ST_IDLE;
				led_n = 1'b1;
			end
		end
	end

	always_comb begin
		case (rs_sel_q)
			2'd0: begin
				rs_period = update_period_q;
			end
			2'd1: begin
				rs_period = key_period_q;
			end
			2'd2: begin
				rs_period = flash_period_q;
			end
			default: begin
				rs_period = blink_period_q;
			end
		endcase
		rs_div   = acsc_pkg::period_ext(rs_period);
		rs_sh    = {rs_rem_q, tick_q[rs_bit_q]};
		rs_rem_n = (rs_sh >= rs_div) ? rs_sh - rs_div : rs_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_period_q <= acsc_pkg::UPDATE_PERIOD_RST;
			key_period_q    <= acsc_pkg::KEY_PERIOD_RST;
			flash_period_q  <= acsc_pkg::FLASH_PERIOD_RST;
			blink_period_q  <= acsc_pkg::BLINK_PERIOD_RST;
			wrap_limit_q    <= acsc_pkg::WRAP_LIMIT_RST;
			flash_count_q   <= acsc_pkg::FLASH_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				acsc_pkg::CFG_UPDATE_PERIOD: begin
					update_period_q <= cfg_data;
				end
				acsc_pkg::CFG_KEY_PERIOD: begin
					key_period_q <= cfg_data;
				end
				acsc_pkg::CFG_FLASH_PERIOD: begin
					flash_period_q <= cfg_data;
				end
				acsc_pkg::CFG_BLINK_PERIOD: begin
					blink_period_q <= cfg_data;
				end
				acsc_pkg::CFG_WRAP_LIMIT: begin
					wrap_limit_q <= cfg_data;
				end
				acsc_pkg::CFG_FLASH_COUNT: begin
					flash_count_q <= cfg_data[5:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1    <= key_code;
			hour_s1   <= clock_hour_bcd;
			minute_s1 <= clock_minute_bcd;
			second_s1 <= clock_second_bcd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_q <= 1'b0;
			rs_sel_q <= 2'd0;
			rs_bit_q <= 4'd15;
			rs_rem_q <= 16'd0;
		end else if (cfg_write) begin
			resync_q <= 1'b1;
			rs_sel_q <= 2'd0;
			rs_bit_q <= 4'd15;
			rs_rem_q <= 16'd0;
		end else if (resync_q) begin
			if (rs_bit_q == 4'd0) begin
				rs_bit_q <= 4'd15;
				rs_rem_q <= 16'd0;
				rs_sel_q <= rs_sel_q + 2'd1;
				resync_q <= (rs_sel_q != 2'd3);
			end else begin
				rs_bit_q <= rs_bit_q - 4'd1;
				rs_rem_q <= rs_rem_n[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= 16'd0;
			res_upd_q      <= 16'd0;
			res_key_q      <= 16'd0;
			res_flash_q    <= 16'd0;
			res_blink_q    <= 16'd0;
			run_hour_q     <= acsc_pkg::RUN_HOUR_RST;
			run_minute_q   <= acsc_pkg::RUN_MINUTE_RST;
			run_second_q   <= acsc_pkg::RUN_SECOND_RST;
			alarm_hour_q   <= 5'd0;
			alarm_minute_q <= 6'd0;
			alarm_second_q <= 6'd0;
			set_mode_q     <= MODE_NONE;
			main_state_q   <= ST_IDLE;
			blink_q        <= 1'b0;
			flash_flag_q   <= 1'b1;
			led_q          <= 1'b1;
			flash_cnt_q    <= 6'd0;
			for (int i = 0; i < 6; i++) begin
				dig_q[i] <= acsc_pkg::DIGIT_RST[i];
			end
		end else if (advance) begin
			tick_q         <= tick_n;
			res_upd_q      <= ru2;
			res_key_q      <= rk2;
			res_flash_q    <= rf2;
			res_blink_q    <= rb2;
			run_hour_q     <= rh[4:0];
			run_minute_q   <= rm;
			run_second_q   <= rs;
			alarm_hour_q   <= ah[4:0];
			alarm_minute_q <= am;
			alarm_second_q <= as_n;
			set_mode_q     <= sm;
			main_state_q   <= ms;
			blink_q        <= blink_n;
			flash_flag_q   <= ff_n;
			led_q          <= led_n;
			flash_cnt_q    <= fc_n;
			for (int i = 0; i < 6; i++) begin
				dig_q[i] <= dig_n[i];
			end
		end else if (resync_q && rs_bit_q == 4'd0) begin
			case (rs_sel_q)
				2'd0: begin
					res_upd_q <= rs_rem_n[15:0];
				end
				2'd1: begin
					res_key_q <= rs_rem_n[15:0];
				end
				2'd2: begin
					res_flash_q <= rs_rem_n[15:0];
				end
				default: begin
					res_blink_q <= rs_rem_n[15:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hour_tens        <= dig_n[0];
			hour_ones        <= dig_n[1];
			minute_tens      <= dig_n[2];
			minute_ones      <= dig_n[3];
			second_tens      <= dig_n[4];
			second_ones      <= dig_n[5];
			led_level        <= led_n;
			write_strobe     <= wr_n;
			write_hour_bcd   <= wr_n ? 6'(acsc_pkg::to_bcd(rh)) : 6'd0;
			write_minute_bcd <= wr_n ? acsc_pkg::to_bcd(rm) : 7'd0;
			write_second_bcd <= wr_n ? acsc_pkg::to_bcd(rs) : 7'd0;
		end
	end

	`ACSC_ASSERT_IMP(a_resync_blocks_input, resync_q, !in_ready)
	`ACSC_ASSERT_NXT(a_cfg_starts_resync, cfg_write, resync_q)
	`ACSC_ASSERT_IMP(a_no_write_zero_fields, out_valid && !write_strobe,
		write_hour_bcd == 6'd0 && write_minute_bcd == 7'd0 && write_second_bcd == 7'd0)
	`ACSC_ASSERT_IMP(a_write_hour_bcd_legal, out_valid && write_strobe,
		write_hour_bcd[3:0] <= 4'd9 && write_hour_bcd <= 6'h23)
	`ACSC_ASSERT_IMP(a_setting_has_mode,
		main_state_q == ST_HOUR || main_state_q == ST_MINUTE || main_state_q == ST_SECOND,
		set_mode_q != MODE_NONE)

endmodule

`default_nettype wire
